// ===== rtl/arx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and round functions of the ARX block cipher.
package arx_pkg;

   localparam int WordW   = 32;
   localparam int CsrIdxW = 2;
   localparam int NumKeyMixes = 12;

   typedef logic [WordW-1:0] word_type;
   typedef word_type [3:0] block_type;

   typedef struct packed {
      word_type plain_word0;
      word_type plain_word1;
      word_type plain_word2;
      word_type plain_word3;
   } req_word_type;

   typedef struct packed {
      word_type cipher_word0;
      word_type cipher_word1;
      word_type cipher_word2;
      word_type cipher_word3;
   } rsp_word_type;

   // What one pipeline stage does to the block before its register.
   typedef enum logic [2:0] {
      OP_PASS,
      OP_MIX,
      OP_WHITEN_MIX,
      OP_XOR_MIX,
      OP_FINAL
   } stage_op_type;

   function automatic word_type rotl(word_type x, logic [4:0] n);
      return (x << n) | (x >> (6'd32 - {1'b0, n}));
   endfunction

   function automatic word_type pick(word_type s, word_type x, word_type y);
      return y ^ (s & (x ^ y));
   endfunction

   // One add-rotate-XOR mixing of word m with the other three words.
   function automatic block_type mix_step(block_type w, logic [1:0] m);
      word_type  a;
      word_type  b;
      word_type  c;
      word_type  d;
      word_type  v;
      logic [4:0] r1;
      logic [4:0] r2;
      block_type res;
      unique case (m)
         2'd0: begin
            r1 = 5'd1;
            r2 = 5'd11;
         end
         2'd1: begin
            r1 = 5'd2;
            r2 = 5'd7;
         end
         2'd2: begin
            r1 = 5'd3;
            r2 = 5'd15;
         end
         default: begin
            r1 = 5'd5;
            r2 = 5'd17;
         end
      endcase
      a = w[m];
      b = w[m + 2'd1];
      c = w[m + 2'd2];
      d = w[m + 2'd3];
      v = a + (b ^ c ^ d);
      v = rotl(v, r1);
      v = v ^ pick(b, c, d);
      res = w;
      res[m] = rotl(v, r2);
      return res;
   endfunction

   // Keyed choice swaps on the word pairs (0,1), (2,3), (0,2) and (1,3).
   function automatic block_type shuffle(block_type w, block_type rk);
      block_type res;
      word_type  x;
      word_type  y;
      res = w;
      x = res[0];
      y = res[1];
      res[0] = pick(rk[0], x, y);
      res[1] = pick(rk[0], y, x);
      x = res[2];
      y = res[3];
      res[2] = pick(rk[1], x, y);
      res[3] = pick(rk[1], y, x);
      x = res[0];
      y = res[2];
      res[0] = pick(rk[2], x, y);
      res[2] = pick(rk[2], y, x);
      x = res[1];
      y = res[3];
      res[1] = pick(rk[3], x, y);
      res[3] = pick(rk[3], y, x);
      return res;
   endfunction

endpackage

// ===== rtl/arx_key_sched.sv =====
`timescale 1ns / 1ps
// Free-running round key schedule: three key permutations as twelve mixing stages.
module arx_key_sched
   import arx_pkg::*;
(
   input  logic      clock,
   input  block_type key,
   output block_type rkey0,
   output block_type rkey1,
   output block_type rkey2
);

   block_type t_ff [NumKeyMixes];
   block_type t_in [NumKeyMixes];

   // The chain recomputes every cycle, so a new key settles once it has passed through all twelve mixing registers.
   for (genvar j = 0; j < NumKeyMixes; j++) begin : g_mix
      localparam logic [1:0] Sel = 2'(j % 4);
      if (j == 0) begin : g_first
         assign t_in[j] = mix_step(key, Sel);
      end else begin : g_next
         assign t_in[j] = mix_step(t_ff[j-1], Sel);
      end

      always_ff @(posedge clock) begin
         t_ff[j] <= t_in[j];
      end
   end

   assign rkey0 = t_ff[3] ^ key;
   assign rkey1 = t_ff[7] ^ key;
   assign rkey2 = t_ff[11] ^ key;

endmodule

// ===== rtl/arx_pipe_stage.sv =====
`timescale 1ns / 1ps
// One register stage of the cipher pipeline with its optional key step and mixing.
module arx_pipe_stage
   import arx_pkg::*;
#(
   parameter stage_op_type OP      = OP_PASS,
   parameter int           MIX_IDX = 0
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      enable,
   input  logic      in_valid,
   input  block_type in_block,
   input  block_type rkey,
   output logic      out_valid,
   output block_type out_block
);

   localparam logic [1:0] MixSel = MIX_IDX[1:0];

   logic      valid_ff;
   block_type block_ff;
   block_type block_in;

   always_comb begin
      unique case (OP)
         OP_PASS:       block_in = in_block;
         OP_MIX:        block_in = mix_step(in_block, MixSel);
         OP_WHITEN_MIX: block_in = mix_step(shuffle(in_block ^ rkey, rkey), MixSel);
         OP_XOR_MIX:    block_in = mix_step(in_block ^ rkey, MixSel);
         OP_FINAL:      block_in = shuffle(in_block ^ rkey, rkey);
         default:       block_in = in_block;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         block_ff <= block_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_block = block_ff;

endmodule

// ===== rtl/arx_out_skid.sv =====
`timescale 1ns / 1ps
// Output register with a one-word skid stage that decouples the pipeline from rsp_stall.
module arx_out_skid
   import arx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         pipe_valid,
   input  rsp_word_type pipe_data,
   output logic         pipe_enable,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_word_type rsp_data_ff;
   rsp_word_type rsp_data_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   rsp_word_type skid_data_ff;
   rsp_word_type skid_data_in;
   logic         out_take;

   assign out_take = rsp_valid_ff && !rsp_stall;

   // While the skid stage holds a word the pipeline is frozen.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_take || !rsp_valid_ff) begin
         rsp_valid_in = pipe_valid;
         rsp_data_in  = pipe_data;
      end else if (pipe_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = pipe_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign pipe_enable = !skid_valid_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

endmodule

// ===== rtl/arx_block_cipher_encrypt_128.sv =====
`timescale 1ns / 1ps
// Pipelined 128-bit ARX block cipher, encryption only.
//
// Load the four key words through the csr_ port (index 0 to 3) while no block is in
// flight; a block may follow a key write in the very next cycle. Plaintext words enter
// on req_ (req_valid/req_stall) and ciphertext words leave on rsp_ (rsp_valid/rsp_stall).
// One block is accepted per cycle while req_stall is low. Every block passes through
// 8*ROUNDS_PER_HALF+5 register stages (four delay stages, one add-rotate-XOR mixing per
// stage after them and a final shuffle stage) plus the output register that drives
// rsp_valid and rsp_data.
// Round keys come from a separate twelve-stage schedule chain fed by the key registers.
// Reset clears the key to zero and empties the pipeline; no clearing pass is needed.
// When the receiver stalls, the result waits in the output register and one further
// word drops into a skid stage; only then does req_stall rise and the whole pipeline
// hold, losing nothing.
module arx_block_cipher_encrypt_128
   import arx_pkg::*;
#(
   parameter int ROUNDS_PER_HALF = 10
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_word_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_word_type       rsp_data,
   input  logic               csr_wr_en,
   input  logic [CsrIdxW-1:0] csr_index,
   input  word_type           csr_wdata
);

   localparam int HalfStages = 4 * ROUNDS_PER_HALF;
   localparam int NumStages  = 2 * HalfStages + 5;

   block_type key_ff;
   block_type rkey0;
   block_type rkey1;
   block_type rkey2;
   logic      enable;

   logic [NumStages:0] stg_valid;
   block_type          stg_block [NumStages+1];
   block_type          pipe_block;
   rsp_word_type       pipe_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_wr_en) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   arx_key_sched u_key_sched (
      .clock (clock),
      .key   (key_ff),
      .rkey0 (rkey0),
      .rkey1 (rkey1),
      .rkey2 (rkey2)
   );

   assign req_stall    = !enable;
   assign stg_valid[0] = req_valid;

   always_comb begin
      stg_block[0][0] = req_data.plain_word0;
      stg_block[0][1] = req_data.plain_word1;
      stg_block[0][2] = req_data.plain_word2;
      stg_block[0][3] = req_data.plain_word3;
   end

   // The first four stages only delay the block until round key 0 has settled.
   for (genvar s = 0; s < NumStages; s++) begin : g_stage
      localparam stage_op_type SOp =
         (s < 4)                  ? OP_PASS :
         (s == 4)                 ? OP_WHITEN_MIX :
         (s == 4 + HalfStages)    ? OP_XOR_MIX :
         (s == 4 + 2*HalfStages)  ? OP_FINAL : OP_MIX;
      localparam int SMix = (s + 4) % 4;

      block_type stage_rkey;

      if (s < 4 + HalfStages) begin : g_rk0
         assign stage_rkey = rkey0;
      end else if (s < 4 + 2*HalfStages) begin : g_rk1
         assign stage_rkey = rkey1;
      end else begin : g_rk2
         assign stage_rkey = rkey2;
      end

      arx_pipe_stage #(
         .OP      (SOp),
         .MIX_IDX (SMix)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (stg_valid[s]),
         .in_block  (stg_block[s]),
         .rkey      (stage_rkey),
         .out_valid (stg_valid[s+1]),
         .out_block (stg_block[s+1])
      );
   end

   assign pipe_block = stg_block[NumStages];

   always_comb begin
      pipe_data.cipher_word0 = pipe_block[0];
      pipe_data.cipher_word1 = pipe_block[1];
      pipe_data.cipher_word2 = pipe_block[2];
      pipe_data.cipher_word3 = pipe_block[3];
   end

   arx_out_skid u_out_skid (
      .clock       (clock),
      .reset       (reset),
      .pipe_valid  (stg_valid[NumStages]),
      .pipe_data   (pipe_data),
      .pipe_enable (enable),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
